// ===== hw/rtl/rgb2d_pkg.sv =====
`default_nettype none
package rgb2d_pkg;

  typedef struct packed {
    logic               command;
    logic signed [15:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               empty_res;
  } out_word_t;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [2:0] REG_GAIN_B   = 3'd0;
  localparam logic [2:0] REG_FB_ONE   = 3'd1;
  localparam logic [2:0] REG_FB_TWO   = 3'd2;
  localparam logic [2:0] REG_FB_THREE = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;

  localparam int unsigned COEF_W = 24;
  localparam int unsigned LINE_W = 40;
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned DIM_W  = 9;

  // Saturate a 64-bit signed value to 40 bits
  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd549755813887;
    lo = -64'sd549755813888;
    if (v > hi) sat40 = hi[39:0];
    else if (v < lo) sat40 = lo[39:0];
    else sat40 = v[39:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) sat32 = hi[31:0];
    else if (v < lo) sat32 = lo[31:0];
    else sat32 = v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rgb2d_ram.sv =====
`default_nettype none
module rgb2d_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rgb2d_mac.sv =====
`default_nettype none
// One coefficient product per cycle, rounded to Q.8, added into the sum.
module rgb2d_mac #(
  parameter int unsigned CoefFracBits = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                clear_i,
  input  wire logic                en_i,
  input  wire logic signed [23:0]  coef_i,
  input  wire logic signed [39:0]  data_i,
  output logic signed [63:0]       acc_o
);
  logic signed [63:0] prod_q, prod_d;
  logic               pv_q;
  logic               clr_q;
  logic signed [63:0] acc_q, acc_d;

  always_comb begin
    prod_d = (64'(coef_i) * 64'(data_i)) + (64'sd1 <<< (CoefFracBits - 1));
    prod_d = prod_d >>> CoefFracBits;
  end

  always_comb begin
    acc_d = acc_q;
    if (pv_q) acc_d = (clr_q ? 64'sd0 : acc_q) + prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      clr_q <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q  <= en_i;
      clr_q <= clear_i;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

// ===== hw/rtl/recursive_gaussian_blur_2d.sv =====
`default_nettype none
// Recursive Gaussian blur, third order, over one image band.
//
// Input channel (in_valid_i/in_ready_o/in_word_i): a word with command 0
// pushes one sample in raster order, and is dropped in readout; command 1
// reads one result. A push gives no output word; a read gives exactly one
// output word on out_valid_o/out_ready_i (value, last flag, empty_res flag).
// Once width*height samples are in, the frame store is filtered in place:
// causal then anticausal pass along every row, then along every column
// when the height exceeds one. During filtering the input is held off.
// Each sample of a row or column goes through the causal pass, the
// anticausal pass and the write-back, paced by the single shared
// multiplier doing four products per sample in each pass and the
// registered reads of the line and frame memories.
// A read in readout passes through S_READ and S_RWAIT before its word is
// valid; a read while loading answers in the cycle after acceptance.
// A stalled receiver holds the result register and stalls the input.
// Reset returns to loading with empty counters; memory contents are
// undefined until written, and coefficient registers take their defaults.
module recursive_gaussian_blur_2d #(
  parameter int unsigned MAX_WIDTH      = 256,
  parameter int unsigned MAX_HEIGHT     = 256,
  parameter int unsigned COEF_FRAC_BITS = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [23:0]           cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire rgb2d_pkg::in_word_t   in_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output rgb2d_pkg::out_word_t       out_word_o
);
  localparam int unsigned StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW        = $clog2(StoreSize);
  localparam int unsigned CW        = $clog2(StoreSize + 1);
  localparam int unsigned LineLen   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned LW        = (LineLen > 1) ? $clog2(LineLen) : 1;
  localparam int unsigned NW        = $clog2(LineLen + 1);

  // controller states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_RWAIT = 4'd2;
  localparam logic [3:0] S_LINE  = 4'd3;
  localparam logic [3:0] S_FRD   = 4'd4;
  localparam logic [3:0] S_FMUL  = 4'd5;
  localparam logic [3:0] S_FWR   = 4'd6;
  localparam logic [3:0] S_BRD   = 4'd7;
  localparam logic [3:0] S_BMUL  = 4'd8;
  localparam logic [3:0] S_BWR   = 4'd9;
  localparam logic [3:0] S_WB    = 4'd10;
  localparam logic [3:0] S_WBW   = 4'd11;

  // configuration registers
  logic signed [23:0] coef_q [4];
  logic [8:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= 24'sd106566;
      coef_q[1] <= 24'sd1781701;
      coef_q[2] <= -24'sd1067052;
      coef_q[3] <= 24'sd227373;
      width_q   <= 9'd1;
      height_q  <= 9'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rgb2d_pkg::REG_GAIN_B:   coef_q[0] <= cfg_data_i;
        rgb2d_pkg::REG_FB_ONE:   coef_q[1] <= cfg_data_i;
        rgb2d_pkg::REG_FB_TWO:   coef_q[2] <= cfg_data_i;
        rgb2d_pkg::REG_FB_THREE: coef_q[3] <= cfg_data_i;
        rgb2d_pkg::REG_WIDTH:    width_q   <= cfg_data_i[8:0];
        rgb2d_pkg::REG_HEIGHT:   height_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // clamp dimensions in use
  logic [NW-1:0] w_use, h_use;
  always_comb begin
    if (width_q == 9'd0) w_use = NW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_use = NW'(MAX_WIDTH);
    else w_use = NW'(width_q);
    if (height_q == 9'd0) h_use = NW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_use = NW'(MAX_HEIGHT);
    else h_use = NW'(height_q);
  end
  logic [CW-1:0] total;
  assign total = CW'(w_use) * CW'(h_use);

  // memories
  logic          st_we;
  logic [AW-1:0] st_wa, st_ra;
  logic [31:0]   st_wd, st_rd;
  logic          fl_we, bl_we;
  logic [LW-1:0] fl_wa, fl_ra, bl_wa, bl_ra;
  logic [39:0]   fl_wd, fl_rd, bl_wd, bl_rd;

  rgb2d_ram #(.Width(32), .Depth(StoreSize)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd),
    .raddr_i(st_ra), .rdata_o(st_rd)
  );
  rgb2d_ram #(.Width(40), .Depth(LineLen)) u_fwd (
    .clk_i, .we_i(fl_we), .waddr_i(fl_wa), .wdata_i(fl_wd),
    .raddr_i(fl_ra), .rdata_o(fl_rd)
  );
  rgb2d_ram #(.Width(40), .Depth(LineLen)) u_bwd (
    .clk_i, .we_i(bl_we), .waddr_i(bl_wa), .wdata_i(bl_wd),
    .raddr_i(bl_ra), .rdata_o(bl_rd)
  );

  // shared multiply-accumulate
  logic               mac_en, mac_clr;
  logic signed [23:0] mac_coef;
  logic signed [39:0] mac_data;
  logic signed [63:0] mac_acc;
  rgb2d_mac #(.CoefFracBits(COEF_FRAC_BITS)) u_mac (
    .clk_i, .rst_ni, .clear_i(mac_clr), .en_i(mac_en),
    .coef_i(mac_coef), .data_i(mac_data), .acc_o(mac_acc)
  );

  // control state
  logic [3:0]    state_q, state_d;
  logic          readout_q, readout_d;
  logic [CW-1:0] load_q, load_d, rcnt_q, rcnt_d;
  logic          colpass_q, colpass_d;
  logic [NW-1:0] line_q, line_d;   // row or column index
  logic [NW-1:0] k_q, k_d;         // position within line
  logic [NW-1:0] n_q, n_d;         // line length
  logic [2:0]    t_q, t_d;         // term index 0..3, plus drain
  logic          ov_q, ov_d;
  logic          ovl_d, ovl_q;
  logic          ove_d, ove_q;
  logic signed [31:0] ovv_d, ovv_q;
  logic          rpend_q, rpend_d;

  // pixel address of position k in current line
  function automatic logic [CW-1:0] pix_addr(input logic col, input logic [NW-1:0] ln,
                                             input logic [NW-1:0] k,
                                             input logic [NW-1:0] w);
    if (col) pix_addr = CW'(k) * CW'(w) + CW'(ln);
    else pix_addr = CW'(ln) * CW'(w) + CW'(k);
  endfunction

  logic [CW-1:0] cur_addr;
  assign cur_addr = pix_addr(colpass_q, line_q, k_q, w_use);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && (!ov_q || out_ready_i);

  logic signed [39:0] line_sat;
  assign line_sat = rgb2d_pkg::sat40(mac_acc);

  // for the current term t: which past index, and is it in range
  logic [NW-1:0] tap_idx;
  logic          tap_ok;
  always_comb begin
    tap_idx = '0;
    tap_ok  = 1'b0;
    if (state_q == S_FRD || state_q == S_FMUL) begin
      tap_ok  = (t_q == 3'd0) || (k_q >= NW'(t_q));
      tap_idx = k_q - NW'(t_q);
    end else begin
      tap_ok  = (t_q == 3'd0) || ((k_q + NW'(t_q)) < n_q);
      tap_idx = k_q + NW'(t_q);
    end
  end

  always_comb begin
    state_d   = state_q;
    readout_d = readout_q;
    load_d    = load_q;
    rcnt_d    = rcnt_q;
    colpass_d = colpass_q;
    line_d    = line_q;
    k_d       = k_q;
    n_d       = n_q;
    t_d       = t_q;
    ov_d      = ov_q;
    ovl_d     = ovl_q;
    ove_d     = ove_q;
    ovv_d     = ovv_q;
    rpend_d   = rpend_q;
    st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
    bl_we = 1'b0; bl_wa = '0; bl_wd = '0; bl_ra = '0;
    mac_en = 1'b0; mac_clr = 1'b0; mac_coef = coef_q[0]; mac_data = '0;

    if (out_acc) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_word_i.command == rgb2d_pkg::CMD_PUSH) begin
            if (!readout_q) begin
              st_we = 1'b1;
              st_wa = AW'(load_q);
              st_wd = 32'(in_word_i.sample) <<< 8;
              if ((load_q + CW'(1)) >= total) begin
                load_d    = '0;
                colpass_d = 1'b0;
                line_d    = '0;
                n_d       = w_use;
                state_d   = S_LINE;
              end else begin
                load_d = load_q + CW'(1);
              end
            end
          end else if (!readout_q) begin
            ov_d = 1'b1; ovv_d = '0; ovl_d = 1'b0; ove_d = 1'b1;
          end else begin
            st_ra   = AW'(rcnt_q);
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        // hold the read address so the word is still there next cycle
        st_ra   = AW'(rcnt_q);
        state_d = S_RWAIT;
        if ((rcnt_q + CW'(1)) >= total) begin
          ovl_d = 1'b1; rcnt_d = '0; readout_d = 1'b0;
        end else begin
          ovl_d = 1'b0; rcnt_d = rcnt_q + CW'(1);
        end
      end
      S_RWAIT: begin
        ov_d = 1'b1; ovv_d = st_rd; ove_d = 1'b0;
        state_d = S_IDLE;
      end
      S_LINE: begin
        k_d = '0; t_d = '0;
        state_d = S_FRD;
      end
      S_FRD, S_BRD: begin
        // issue read for term t, or start drain after last term
        if (t_q <= 3'd3) begin
          st_ra = AW'(cur_addr);
          fl_ra = LW'(t_q == 3'd0 ? k_q : tap_idx);
          bl_ra = LW'(tap_idx);
          state_d = (state_q == S_FRD) ? S_FMUL : S_BMUL;
        end else begin
          state_d = (state_q == S_FRD) ? S_FWR : S_BWR;
        end
      end
      S_FMUL, S_BMUL: begin
        mac_en   = tap_ok;
        mac_clr  = (t_q == 3'd0);
        mac_coef = coef_q[t_q[1:0]];
        if (state_q == S_FMUL)
          mac_data = (t_q == 3'd0) ? 40'(signed'(st_rd)) : fl_rd;
        else
          mac_data = (t_q == 3'd0) ? fl_rd : bl_rd;
        t_d = t_q + 3'd1;
        state_d = (state_q == S_FMUL) ? S_FRD : S_BRD;
      end
      S_FWR: begin
        // product pipe has one more stage: wait via t
        if (t_q == 3'd4) begin
          t_d = 3'd5;
        end else begin
          fl_we = 1'b1; fl_wa = LW'(k_q); fl_wd = line_sat;
          t_d = '0;
          if (k_q + NW'(1) >= n_q) begin
            k_d = n_q - NW'(1);
            state_d = S_BRD;
          end else begin
            k_d = k_q + NW'(1);
            state_d = S_FRD;
          end
        end
      end
      S_BWR: begin
        if (t_q == 3'd4) begin
          t_d = 3'd5;
        end else begin
          bl_we = 1'b1; bl_wa = LW'(k_q); bl_wd = line_sat;
          t_d = '0;
          if (k_q == '0) begin
            state_d = S_WB;
          end else begin
            k_d = k_q - NW'(1);
            state_d = S_BRD;
          end
        end
      end
      S_WB: begin
        bl_ra = LW'(k_q);
        state_d = S_WBW;
      end
      S_WBW: begin
        st_we = 1'b1;
        st_wa = AW'(cur_addr);
        st_wd = rgb2d_pkg::sat32(bl_rd);
        if (k_q + NW'(1) < n_q) begin
          k_d = k_q + NW'(1);
          state_d = S_WB;
        end else if (line_q + NW'(1) < (colpass_q ? w_use : h_use)) begin
          line_d = line_q + NW'(1);
          state_d = S_LINE;
        end else if (!colpass_q && h_use > NW'(1)) begin
          colpass_d = 1'b1; line_d = '0; n_d = h_use;
          state_d = S_LINE;
        end else begin
          readout_d = 1'b1; rcnt_d = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    rpend_d = (state_d == S_READ) || (state_d == S_RWAIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      readout_q <= 1'b0;
      load_q    <= '0;
      rcnt_q    <= '0;
      colpass_q <= 1'b0;
      line_q    <= '0;
      k_q       <= '0;
      n_q       <= NW'(1);
      t_q       <= '0;
      ov_q      <= 1'b0;
      rpend_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      readout_q <= readout_d;
      load_q    <= load_d;
      rcnt_q    <= rcnt_d;
      colpass_q <= colpass_d;
      line_q    <= line_d;
      k_q       <= k_d;
      n_q       <= n_d;
      t_q       <= t_d;
      ov_q      <= ov_d;
      rpend_q   <= rpend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovv_q <= ovv_d;
    ovl_q <= ovl_d;
    ove_q <= ove_d;
  end

  assign out_valid_o          = ov_q;
  assign out_word_o.value     = ovv_q;
  assign out_word_o.last      = ovl_q;
  assign out_word_o.empty_res = ove_q;

  // hold off input while a read is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) rpend_q |-> !in_ready_o)
    else $error("input accepted during read");
  // a filtering run never starts with a word pending in readout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_LINE) |-> !readout_q)
    else $error("filtering while in readout");
  // an empty result, given only while loading, never carries the last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_word_o.empty_res) |-> !out_word_o.last)
    else $error("empty result flagged last");
endmodule
`default_nettype wire

// ===== tb/recursive_gaussian_blur_2d_tb.sv =====
`timescale 1ns / 1ps

module recursive_gaussian_blur_2d_tb;

  localparam int unsigned MAX_W      = 256;
  localparam int unsigned MAX_H      = 256;
  localparam int unsigned FRAC       = 20;
  localparam int unsigned CYCLE_CAP  = 800000;
  // random words on top of the directed frames, about 500 words
  localparam int unsigned WORD_GOAL  = 500;

  // Holds its own copy of the coefficients, the frame store and the line buffers,
  // and works out the word each read must return.
  class blur_scoreboard;
    longint      gain, fb1, fb2, fb3;
    int unsigned width_reg, height_reg;
    logic signed [31:0] frame_mem [MAX_W*MAX_H];
    longint      fwd_line [MAX_W];
    longint      bwd_line [MAX_W];
    int unsigned load_cnt, read_cnt, written;
    bit          readout;
    rgb2d_pkg::out_word_t pixel_q [$];
    int unsigned errors, n_results, n_empty, n_frames, n_words;

    function new();
      gain = 106566; fb1 = 1781701; fb2 = -1067052; fb3 = 227373;
      width_reg = 1; height_reg = 1;
      foreach (frame_mem[i]) frame_mem[i] = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] d);
      case (idx)
        rgb2d_pkg::REG_GAIN_B:   gain = longint'(signed'(d));
        rgb2d_pkg::REG_FB_ONE:   fb1 = longint'(signed'(d));
        rgb2d_pkg::REG_FB_TWO:   fb2 = longint'(signed'(d));
        rgb2d_pkg::REG_FB_THREE: fb3 = longint'(signed'(d));
        rgb2d_pkg::REG_WIDTH:    width_reg = 32'(d[8:0]);
        rgb2d_pkg::REG_HEIGHT:   height_reg = 32'(d[8:0]);
        default: ;
      endcase
    endfunction

    function int unsigned dim(int unsigned r, int unsigned mx);
      if (r == 0) return 1;
      return (r > mx) ? mx : r;
    endfunction

    function int unsigned frame_words();
      return dim(width_reg, MAX_W) * dim(height_reg, MAX_H);
    endfunction

    // Round each product to Q.8, half up
    function longint cmul(longint c, longint v);
      return (c * v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function longint sat(longint v, int unsigned bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void blur_line(int unsigned base, int unsigned stride, int unsigned n);
      longint acc;
      for (int unsigned k = 0; k < n; k++) begin
        acc = cmul(gain, longint'(frame_mem[base + k*stride]));
        if (k > 0) acc += cmul(fb1, fwd_line[k-1]);
        if (k > 1) acc += cmul(fb2, fwd_line[k-2]);
        if (k > 2) acc += cmul(fb3, fwd_line[k-3]);
        fwd_line[k] = sat(acc, 40);
      end
      for (int k = n - 1; k >= 0; k--) begin
        acc = cmul(gain, fwd_line[k]);
        if (k + 1 < n) acc += cmul(fb1, bwd_line[k+1]);
        if (k + 2 < n) acc += cmul(fb2, bwd_line[k+2]);
        if (k + 3 < n) acc += cmul(fb3, bwd_line[k+3]);
        bwd_line[k] = sat(acc, 40);
      end
      for (int unsigned k = 0; k < n; k++)
        frame_mem[base + k*stride] = 32'(sat(bwd_line[k], 32));
    endfunction

    function void note_input(rgb2d_pkg::in_word_t w);
      rgb2d_pkg::out_word_t e;
      int unsigned total, fw, fh;
      total = frame_words();
      if (w.command == rgb2d_pkg::CMD_PUSH) begin
        if (readout) return;              // dropped by the block
        n_words++;
        frame_mem[load_cnt] = 32'(longint'(w.sample) * 256);
        load_cnt++;
        if (load_cnt > written) written = load_cnt;
        if (load_cnt >= total) begin
          fw = dim(width_reg, MAX_W);
          fh = dim(height_reg, MAX_H);
          for (int unsigned r = 0; r < fh; r++) blur_line(r*fw, 1, fw);
          if (fh > 1)
            for (int unsigned c = 0; c < fw; c++) blur_line(c, fw, fh);
          load_cnt = 0; read_cnt = 0; readout = 1; n_frames++;
        end
        return;
      end
      n_words++;
      e = '0;
      if (!readout) begin
        e.empty_res = 1'b1;
      end else begin
        e.value = frame_mem[read_cnt];
        read_cnt++;
        if (read_cnt >= total) begin
          e.last = 1'b1; read_cnt = 0; readout = 0;
        end
      end
      pixel_q.push_back(e);
    endfunction

    function void check_result(rgb2d_pkg::out_word_t r);
      rgb2d_pkg::out_word_t e;
      if (pixel_q.size() == 0) begin
        $error("unexpected result word: value %0d last %0b empty_res %0b",
               r.value, r.last, r.empty_res);
        errors++;
        return;
      end
      e = pixel_q.pop_front();
      n_results++;
      if (e.empty_res) n_empty++;
      if (r.value !== e.value) begin
        $error("value: expected %0d, got %0d", e.value, r.value); errors++;
      end
      if (r.last !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, r.last); errors++;
      end
      if (r.empty_res !== e.empty_res) begin
        $error("empty_res: expected %0b, got %0b", e.empty_res, r.empty_res); errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [2:0]           cfg_index;
  logic [23:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  rgb2d_pkg::in_word_t  in_word;
  logic                 out_valid;
  logic                 out_ready;
  rgb2d_pkg::out_word_t out_word;

  blur_scoreboard sb;
  int unsigned    send_idle, recv_idle, cycles;

  recursive_gaussian_blur_2d u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: stall at random, check every accepted word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(out_word);
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: a hung handshake or a stuck filter ends the run here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one word; hold valid and payload until the block takes it
  task automatic send_word(input logic cmd, input logic signed [15:0] s);
    rgb2d_pkg::in_word_t w;
    w.command = cmd;
    w.sample  = s;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(w);
  endtask

  // Drop valid, wait out every pending result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [23:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Dimension writes carry junk in the unused upper bits
  task automatic write_dim(input logic [2:0] idx, input int unsigned v);
    logic [23:0] d;
    d = 24'($urandom);
    d[8:0] = v[8:0];
    write_cfg(idx, d);
  endtask

  task automatic write_coefs(input longint g, b1, b2, b3);
    write_cfg(rgb2d_pkg::REG_GAIN_B, 24'(g));
    write_cfg(rgb2d_pkg::REG_FB_ONE, 24'(b1));
    write_cfg(rgb2d_pkg::REG_FB_TWO, 24'(b2));
    write_cfg(rgb2d_pkg::REG_FB_THREE, 24'(b3));
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Load one frame (with stray reads while loading), then read it all back.
  // Optionally shrink the frame part-way through loading, or resize it part-way through reading.
  task automatic run_frame(input int unsigned wr, hr, input bit mid_load, mid_read);
    int unsigned half, nw, nh;
    bit          moved;
    drain();
    write_dim(rgb2d_pkg::REG_WIDTH, wr);
    write_dim(rgb2d_pkg::REG_HEIGHT, hr);
    half  = sb.frame_words() / 2;
    moved = 1'b0;
    while (!sb.readout) begin
      if (mid_load && !moved && sb.load_cnt >= half && half > 0) begin
        drain();
        write_dim(rgb2d_pkg::REG_HEIGHT, $urandom_range(1, sb.dim(hr, MAX_H)));
        moved = 1'b1;
      end
      if ($urandom_range(99) < 8) send_word(rgb2d_pkg::CMD_READ, 16'($urandom));
      else send_word(rgb2d_pkg::CMD_PUSH, pick_sample());
    end
    moved = 1'b0;
    while (sb.readout) begin
      if (mid_read && !moved && sb.read_cnt >= 1) begin
        // the first read has been accepted, so filtering is over
        drain();
        nw = $urandom_range(1, 16);
        if (nw > sb.written) nw = sb.written;
        nh = $urandom_range(1, sb.written / nw);
        write_dim(rgb2d_pkg::REG_WIDTH, nw);
        write_dim(rgb2d_pkg::REG_HEIGHT, nh);
        moved = 1'b1;
      end
      if ($urandom_range(99) < 4) send_word(rgb2d_pkg::CMD_PUSH, 16'($urandom));
      else send_word(rgb2d_pkg::CMD_READ, 16'($urandom));
    end
  endtask

  initial begin
    int unsigned goal;
    sb        = new();
    cycles    = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = rgb2d_pkg::REG_GAIN_B;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: read before anything is loaded, default coefficients
    send_word(rgb2d_pkg::CMD_READ, 16'sh7FFF);
    send_word(rgb2d_pkg::CMD_READ, 16'sh8000);
    run_frame(1, 1, 0, 0);
    // zero dimensions fall back to one
    run_frame(0, 0, 0, 0);
    // coefficient extremes, heavy saturation
    drain();
    write_coefs(8388607, -8388608, 8388607, -8388608);
    run_frame(4, 3, 0, 0);
    drain();
    write_coefs(-8388608, 8388607, -8388608, 8388607);
    run_frame(3, 4, 0, 0);
    drain();
    write_coefs(106566, 1781701, -1067052, 227373);
    // oversized dimensions clip to the maximum
    run_frame(511, 1, 0, 0);
    run_frame(1, 511, 0, 0);
    // shrink while loading, then resize while reading back
    run_frame(5, 4, 1, 0);
    run_frame(6, 5, 0, 1);

    // Random frames, three idle regimes
    goal = sb.n_words + WORD_GOAL;
    while (sb.n_words < goal) begin
      if (sb.n_words < goal - 2*WORD_GOAL/3) begin
        send_idle = 24; recv_idle = 57;
      end else if (sb.n_words < goal - WORD_GOAL/3) begin
        send_idle = 57; recv_idle = 24;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      if ($urandom_range(3) == 0) begin
        drain();
        if ($urandom_range(2) == 0)
          write_coefs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        else
          write_coefs(106566 + $urandom_range(0, 40000) - 20000,
                      1781701 + $urandom_range(0, 200000) - 100000,
                      -1067052 + $urandom_range(0, 200000) - 100000,
                      227373 + $urandom_range(0, 100000) - 50000);
      end
      if ($urandom_range(15) == 0)
        run_frame($urandom_range(1, 24), $urandom_range(1, 24),
                  $urandom_range(3) == 0, $urandom_range(3) == 0);
      else
        run_frame($urandom_range(0, 8), $urandom_range(0, 8),
                  $urandom_range(7) == 0, $urandom_range(7) == 0);
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d filtered frames and %0d result words (%0d empty reads),",
             sb.n_frames, sb.n_results, sb.n_empty);
    $display("with coefficient and dimension extremes and resizing mid-frame.");
    if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rgb2d_pkg.sv
hw/rtl/rgb2d_ram.sv
hw/rtl/rgb2d_mac.sv
hw/rtl/recursive_gaussian_blur_2d.sv
tb/recursive_gaussian_blur_2d_tb.sv
